FILE: hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Holds command and status codes, the chain control word and the FSM states.
// No dependencies.
package ple_pkg;

    localparam int LEN_W  = 7;   // width of position and length fields
    localparam int DATA_W = 32;  // width of one list element

    typedef enum logic [3:0] {
        CMD_INS_FRONT = 4'd0,
        CMD_INS_END   = 4'd1,
        CMD_INS_POS   = 4'd2,
        CMD_COUNT     = 4'd3,
        CMD_DEL_FRONT = 4'd4,
        CMD_DEL_END   = 4'd5,
        CMD_DEL_POS   = 4'd6,
        CMD_SHOW_FWD  = 4'd7,
        CMD_SHOW_REV  = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_BADPOS = 2'd2,
        STS_FULL   = 2'd3
    } status_t;

    // Move broadcast to every cell of the chain at once.
    typedef enum logic [2:0] {
        CH_HOLD,
        CH_INSERT,
        CH_DELETE,
        CH_ROT_L,
        CH_ROT_R
    } chain_op_t;

    typedef struct packed {
        chain_op_t          op;
        logic [LEN_W-1:0]   pos;    // insert or delete target
        logic [LEN_W-1:0]   count;  // current list length
        logic [DATA_W-1:0]  data;   // insert value or rotation feed
    } chain_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } state_t;

endpackage

FILE: hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: command decode, display sequencer,
// output register and the chain of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------
//   in      | in_valid/in_ready  | cmd, position, value
//   out     | out_valid/out_ready| value_out, length, status, last
//
// Insert, delete and count complete in the cycle they are accepted: every cell
// shifts at once and the result lands in the output register, so a new command
// can follow as soon as that register is free. A display, once accepted, emits
// one beat per element, one per cycle while out_ready is high, by rotating the
// chain through its ends; the list is back in place after the last beat. The
// block takes no command while a display runs. Reset clears the length and the
// control state; cell contents are undefined until written. A stalled output
// holds its beat and stalls the display sequencer with it.
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [3:0]              cmd,
    input  logic [LEN_W-1:0]        position,
    input  logic signed [DATA_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DATA_W-1:0] value_out,
    output logic [LEN_W-1:0]        length,
    output logic [1:0]              status,
    output logic                    last
);

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              fwd_reg, fwd_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_out_reg, value_out_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;
    logic              out_load;

    chain_ctl_t        ctl;
    logic [LEN_W-1:0]  sel_idx;
    logic [LEN_W-1:0]  ins_pos;
    logic [LEN_W-1:0]  last_idx;
    logic [DATA_W-1:0] tap_val;
    logic              slot_free;
    logic              accept;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] cell_tap [CAPACITY];

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign last_idx  = count_reg - LEN_W'(1);

    // Cell that drives the tap bus: delete target, or the display head.
    always_comb
    begin
        sel_idx = '0;
        if (state_reg == ST_SHOW)
        begin
            sel_idx = fwd_reg ? '0 : last_idx;
        end
        else
        begin
            case (cmd_t'(cmd))
                CMD_DEL_END: sel_idx = last_idx;
                CMD_DEL_POS: sel_idx = position;
                default:     sel_idx = '0;
            endcase
        end
    end

    // OR the one-hot tap outputs of the cells together.
    always_comb
    begin
        tap_val = '0;
        for (int i = 0; i < CAPACITY; i++)
            tap_val = tap_val | cell_tap[i];
    end

    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_INS_FRONT: ins_pos = '0;
            CMD_INS_END:   ins_pos = count_reg;
            default:       ins_pos = position;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && count_reg != '0 &&
                    (cmd_t'(cmd) == CMD_SHOW_FWD || cmd_t'(cmd) == CMD_SHOW_REV))
                    state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (slot_free && rem_reg == LEN_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Chain control and result beat.
    always_comb
    begin
        ctl.op         = CH_HOLD;
        ctl.pos        = ins_pos;
        ctl.count      = count_reg;
        ctl.data       = value;
        count_next     = count_reg;
        rem_next       = rem_reg;
        fwd_next       = fwd_reg;
        out_load       = 1'b0;
        value_out_next = '0;
        length_next    = count_reg;
        status_next    = STS_OK;
        last_next      = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS:
                        begin
                            out_load = 1'b1;
                            if (ins_pos > count_reg)
                                status_next = STS_BADPOS;
                            else if (count_reg >= CAP_LEN)
                                status_next = STS_FULL;
                            else
                            begin
                                ctl.op      = CH_INSERT;
                                count_next  = count_reg + LEN_W'(1);
                                length_next = count_next;
                            end
                        end
                        CMD_COUNT:
                        begin
                            out_load = 1'b1;
                        end
                        CMD_DEL_FRONT, CMD_DEL_END:
                        begin
                            out_load = 1'b1;
                            if (count_reg == '0)
                                status_next = STS_EMPTY;
                            else
                            begin
                                ctl.op         = CH_DELETE;
                                ctl.pos        = sel_idx;
                                value_out_next = tap_val;
                                count_next     = last_idx;
                                length_next    = last_idx;
                            end
                        end
                        CMD_DEL_POS:
                        begin
                            out_load = 1'b1;
                            if (position >= count_reg)
                                status_next = STS_BADPOS;
                            else
                            begin
                                ctl.op         = CH_DELETE;
                                ctl.pos        = position;
                                value_out_next = tap_val;
                                count_next     = last_idx;
                                length_next    = last_idx;
                            end
                        end
                        CMD_SHOW_FWD, CMD_SHOW_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load    = 1'b1;
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                rem_next = count_reg;
                                fwd_next = (cmd_t'(cmd) == CMD_SHOW_FWD);
                            end
                        end
                        default:
                        begin
                            // unknown code: drop the beat, no result
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SHOW:
            begin
                if (slot_free)
                begin
                    // emit the head and rotate it to the far end
                    ctl.op         = fwd_reg ? CH_ROT_L : CH_ROT_R;
                    ctl.data       = tap_val;
                    out_load       = 1'b1;
                    value_out_next = tap_val;
                    last_next      = (rem_reg == LEN_W'(1));
                    rem_next       = rem_reg - LEN_W'(1);
                end
            end
            default:
            begin
                ctl.op = CH_HOLD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_out_reg <= value_out_next;
            length_reg    <= length_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    // Storage chain: cell 0 is the front of the list.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        ple_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .sel       (sel_idx),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[g]),
            .tap       (cell_tap[g])
        );
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign length    = length_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

FILE: hw/rtl/ple_cell.sv
// One storage cell of the list chain: holds a single element.
// Moves its value to or from its neighbors as the broadcast control word says.
// Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  chain_ctl_t        ctl,
    input  logic [LEN_W-1:0]  sel,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    output logic [DATA_W-1:0] val,
    output logic [DATA_W-1:0] tap
);

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [LEN_W-1:0]  last_idx;

    assign last_idx = ctl.count - LEN_W'(1);

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CH_INSERT:
            begin
                // open a gap at pos: cells behind it take from the left
                if (MY_IDX == ctl.pos)
                    val_next = ctl.data;
                else if (MY_IDX > ctl.pos && MY_IDX <= ctl.count)
                    val_next = left_val;
            end
            CH_DELETE:
            begin
                // close the gap at pos: cells from pos on take from the right
                if (MY_IDX >= ctl.pos && MY_IDX < last_idx)
                    val_next = right_val;
            end
            CH_ROT_L:
            begin
                if (MY_IDX == last_idx)
                    val_next = ctl.data;
                else if (MY_IDX < last_idx)
                    val_next = right_val;
            end
            CH_ROT_R:
            begin
                if (MY_IDX == '0)
                    val_next = ctl.data;
                else if (MY_IDX < ctl.count)
                    val_next = left_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign tap = (MY_IDX == sel) ? val_reg : '0;

endmodule

FILE: hw/rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [LEN_W-1:0]  length,
    input logic [1:0]        status
);

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out beat dropped while stalled");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length <= CAP_LEN)
        else $error("length above capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_FULL |-> length == CAP_LEN)
        else $error("full status with list not full");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_EMPTY |-> length == '0)
        else $error("empty status with elements present");

endmodule

bind positional_list_engine_unit ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .length    (length),
    .status    (status)
);

FILE: tb/tb_positional_list_engine_unit.sv
// Self-checking testbench for positional_list_engine_unit: random-stall driver and monitor
// around a queue-based list predictor, with directed corner cases then random command walks.
// Depends on ple_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
    import ple_pkg::*;

    localparam int CAPACITY = 64;

    typedef struct {
        logic [3:0]               cmd;
        logic [LEN_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } list_cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] value_out;
        logic [LEN_W-1:0]         length;
        status_t                  status;
        logic                     last;
    } list_beat_t;

    // Bias of the random walk over the list length.
    typedef enum {
        WALK_GROW,
        WALK_SHRINK,
        WALK_MIXED
    } walk_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [3:0]               cmd = 4'd0;
    logic [LEN_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] value_out;
    logic [LEN_W-1:0]         length;
    logic [1:0]               status;
    logic                     last;

    list_cmd_t                cmd_queue[$];       // commands not yet offered
    list_cmd_t                held_cmd;           // command on the input port
    logic signed [DATA_W-1:0] list_contents[$];   // predicted list, front first
    list_beat_t               expected_beats[$];  // beats still owed by the block
    int                       gen_len = 0;        // list length as seen by the generator
    int                       total_cmds = 0;
    int                       accepted_cmds = 0;
    int                       mismatch_count = 0;

    positional_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_out (value_out),
        .length    (length),
        .status    (status),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle rate in percent. The first third of the commands has the sender idle
    // 35 and the receiver 47, the second third swaps them, the rest runs flat out.
    function automatic int idle_pct(bit sender);
        int phase;
        phase = (total_cmds == 0) ? 0 : (accepted_cmds * 3) / total_cmds;
        case (phase)
            0: return sender ? 35 : 47;
            1: return sender ? 47 : 35;
            default: return 0;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Queue one expected beat; length is the list size after the command.
    function automatic void expect_beat(logic signed [DATA_W-1:0] v, status_t s, logic l);
        list_beat_t b;
        b.value_out = v;
        b.length    = LEN_W'(list_contents.size());
        b.status    = s;
        b.last      = l;
        expected_beats.push_back(b);
    endfunction

    // Apply one accepted command to the predicted list and queue its beats.
    task automatic apply_list_cmd(input list_cmd_t item);
        int                       slot;
        int                       n;
        logic signed [DATA_W-1:0] taken;
        slot = item.pos;
        n    = list_contents.size();
        case (item.cmd)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS:
            begin
                if (item.cmd == CMD_INS_FRONT)
                    slot = 0;
                else if (item.cmd == CMD_INS_END)
                    slot = n;
                // position check wins over the full check
                if (slot > n)
                    expect_beat('0, STS_BADPOS, 1'b1);
                else if (n >= CAPACITY)
                    expect_beat('0, STS_FULL, 1'b1);
                else
                begin
                    list_contents.insert(slot, item.val);
                    expect_beat('0, STS_OK, 1'b1);
                end
            end
            CMD_COUNT:
                expect_beat('0, STS_OK, 1'b1);
            CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS:
            begin
                if (item.cmd == CMD_DEL_FRONT)
                    slot = 0;
                else if (item.cmd == CMD_DEL_END)
                    slot = n - 1;
                if (item.cmd != CMD_DEL_POS && n == 0)
                    expect_beat('0, STS_EMPTY, 1'b1);
                else if (slot >= n)
                    expect_beat('0, STS_BADPOS, 1'b1);
                else
                begin
                    // a one-element list really empties here
                    taken = list_contents[slot];
                    list_contents.delete(slot);
                    expect_beat(taken, STS_OK, 1'b1);
                end
            end
            CMD_SHOW_FWD, CMD_SHOW_REV:
            begin
                if (n == 0)
                    expect_beat('0, STS_EMPTY, 1'b1);
                for (int i = 0; i < n; i++)
                    expect_beat((item.cmd == CMD_SHOW_FWD) ? list_contents[i]
                                                           : list_contents[n - 1 - i],
                                STS_OK, (i == n - 1));
            end
            default:
                ; // unknown codes are dropped without a beat
        endcase
    endtask

    // Queue a command and track the length it leaves behind.
    task automatic push_cmd(input logic [3:0] c, input int p, input logic signed [DATA_W-1:0] v);
        list_cmd_t item;
        item.cmd = c;
        item.pos = LEN_W'(p);
        item.val = v;
        cmd_queue.push_back(item);
        case (c)
            CMD_INS_FRONT, CMD_INS_END:
                if (gen_len < CAPACITY) gen_len++;
            CMD_INS_POS:
                if (p <= gen_len && gen_len < CAPACITY) gen_len++;
            CMD_DEL_FRONT, CMD_DEL_END:
                if (gen_len > 0) gen_len--;
            CMD_DEL_POS:
                if (p < gen_len) gen_len--;
            default:
                ;
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random_insert();
        case ($urandom_range(2))
            0: push_cmd(CMD_INS_FRONT, $urandom_range(CAPACITY), pick_value());
            1: push_cmd(CMD_INS_END, $urandom_range(CAPACITY), pick_value());
            default:
                // mostly a legal slot, now and then any slot up to CAPACITY
                push_cmd(CMD_INS_POS, ($urandom_range(9) == 0) ? $urandom_range(CAPACITY)
                                                               : $urandom_range(gen_len),
                         pick_value());
        endcase
    endtask

    task automatic push_random_delete();
        int p;
        if (gen_len == 0 || $urandom_range(7) == 0)
            p = $urandom_range(gen_len, CAPACITY);
        else
            p = $urandom_range(gen_len - 1);
        case ($urandom_range(2))
            0: push_cmd(CMD_DEL_FRONT, p, $urandom);
            1: push_cmd(CMD_DEL_END, p, $urandom);
            default: push_cmd(CMD_DEL_POS, p, $urandom);
        endcase
    endtask

    // Driver: on acceptance, predict the beats; whenever the port slot frees up,
    // either offer the next command or idle. Hold payload while valid waits.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_list_cmd(held_cmd);
                accepted_cmds <= accepted_cmds + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    held_cmd = cmd_queue.pop_front();
                    cmd      <= held_cmd.cmd;
                    position <= held_cmd.pos;
                    value    <= held_cmd.val;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted beat with the oldest expectation, then
    // pick the next ready level at random.
    always @(posedge clk)
    begin
        list_beat_t exp_beat;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat value_out=%0d length=%0d status=%0d",
                                            value_out, length, status));
                end
                else
                begin
                    exp_beat = expected_beats.pop_front();
                    if (value_out !== exp_beat.value_out)
                        flag_mismatch($sformatf("value_out %0d, expected %0d",
                                                value_out, exp_beat.value_out));
                    if (length !== exp_beat.length)
                        flag_mismatch($sformatf("length %0d, expected %0d",
                                                length, exp_beat.length));
                    if (status !== exp_beat.status)
                        flag_mismatch($sformatf("status %0d, expected %s",
                                                status, exp_beat.status.name()));
                    if (last !== exp_beat.last)
                        flag_mismatch($sformatf("last %0b, expected %0b",
                                                last, exp_beat.last));
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    initial
    begin
        walk_mode_t mode;
        int         random_cmds;
        int         r;

        // Directed: empty-list corners, extremes of value and position, every
        // command, single-element end delete and ignored codes.
        push_cmd(CMD_COUNT, 0, 0);
        push_cmd(CMD_DEL_FRONT, 0, 0);
        push_cmd(CMD_DEL_END, 0, 0);
        push_cmd(CMD_DEL_POS, 0, 0);
        push_cmd(CMD_SHOW_FWD, 0, 0);
        push_cmd(CMD_SHOW_REV, 0, 0);
        push_cmd(CMD_INS_POS, 1, 32'sh1234_5678);
        push_cmd(CMD_INS_FRONT, 0, 32'sh7fff_ffff);
        push_cmd(CMD_DEL_END, 0, 0);
        push_cmd(CMD_INS_END, 0, 32'sh8000_0000);
        push_cmd(CMD_INS_FRONT, 0, -32'sd1);
        push_cmd(CMD_INS_POS, 2, 0);
        push_cmd(CMD_INS_POS, 1, 32'sh5a5a_a5a5);
        push_cmd(CMD_SHOW_FWD, 0, 0);
        push_cmd(CMD_SHOW_REV, 0, 0);
        push_cmd(CMD_DEL_POS, CAPACITY, 0);
        push_cmd(CMD_DEL_POS, 1, 0);
        push_cmd(4'd9, 3, 32'sh0bad_0bad);
        push_cmd(4'd15, CAPACITY, -32'sd1);
        push_cmd(CMD_DEL_FRONT, 0, 0);
        push_cmd(CMD_COUNT, 0, 0);
        push_cmd(CMD_INS_POS, CAPACITY, 32'sh7fff_ffff);
        push_cmd(CMD_DEL_POS, 0, 0);
        push_cmd(CMD_SHOW_FWD, 0, 0);

        // Fill to capacity, then push against the full list from every side
        // and display it whole.
        while (gen_len < CAPACITY)
            push_random_insert();
        push_cmd(CMD_INS_POS, CAPACITY, pick_value());
        push_cmd(CMD_INS_POS, 10, pick_value());
        push_cmd(CMD_INS_FRONT, 0, pick_value());
        push_cmd(CMD_INS_END, 0, pick_value());
        push_cmd(CMD_SHOW_FWD, 0, 0);
        push_cmd(CMD_SHOW_REV, 0, 0);
        push_cmd(CMD_COUNT, 0, 0);

        // Random walk: switch bias every couple dozen commands so the length
        // swings between empty and full.
        mode        = WALK_SHRINK;
        random_cmds = 0;
        while (random_cmds < 170)
        begin
            if (random_cmds % 24 == 23)
                mode = walk_mode_t'($urandom_range(2));
            r = $urandom_range(99);
            if (r < ((mode == WALK_GROW) ? 65 : (mode == WALK_SHRINK) ? 20 : 40))
            begin
                push_random_insert();
                random_cmds++;
            end
            else if (r < 85)
            begin
                push_random_delete();
                random_cmds++;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 10)
                begin
                    push_cmd(4'($urandom_range(9, 15)), $urandom_range(CAPACITY), $urandom);
                end
                else
                begin
                    push_cmd((r < 50) ? CMD_COUNT : (r < 75) ? CMD_SHOW_FWD : CMD_SHOW_REV,
                             $urandom_range(CAPACITY), $urandom);
                    random_cmds++;
                end
            end
        end
        total_cmds = cmd_queue.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all commands taken, all beats seen, then let stray beats show.
        while (cmd_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
